// ===== design/mfac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfac_pkg;

    // Minifloat format: 6-bit exponent (bias 31), 8-bit fraction, hidden one.
    localparam int EXP_BITS  = 6;
    localparam int FRAC_BITS = 8;
    localparam int MINI_BITS = EXP_BITS + FRAC_BITS;

    localparam logic [EXP_BITS-1:0]  EXP_ALL  = 6'h3F;
    localparam logic [EXP_BITS-1:0]  EXP_TOP  = 6'd62;
    localparam logic [EXP_BITS-1:0]  BIAS     = 6'd31;
    localparam logic [MINI_BITS-1:0] OVF_CODE = 14'h3FFF;

    // IEEE single fields
    localparam int           SGL_FRAC_BITS = 23;
    localparam logic [7:0]   SGL_BIAS      = 8'd127;
    localparam logic [31:0]  SGL_MINUS_ONE = 32'hBF80_0000;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_MUL    = 2'd1,
        FUNC_FROM_SGL = 2'd2,
        FUNC_TO_SGL = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_NORMAL    = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_UNUSED    = 2'd3
    } status_t;

    typedef struct packed {
        func_t                func;
        logic [31:0]          operand_a;
        logic [MINI_BITS-1:0] operand_b;
    } req_item_t;

    typedef struct packed {
        logic [31:0] result;
        status_t     status;
    } rsp_item_t;

endpackage

`default_nettype wire

// ===== design/mfac_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mfac_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/minifloat_add_mul_convert_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Modport  Payload                               Role
// req      sink     func, operand_a[31:0], operand_b[13:0] operation and operands
// rsp      source   result[31:0], status[1:0]             one result item per req item
//
// Each item passes an operand register, one pass of add / multiply / convert
// logic, and a result register: rsp.valid rises when the item moves from the
// operand register into the result register.
// One item is accepted every cycle while rsp does not stall; the 9x9 mantissa
// multiplier and the alignment shifter sit between the two registers.
// rst_n clears both valid flags asynchronously; payload registers are not reset.
// A stall on rsp holds the result register and, when the operand register is
// also full, drops req.ready in the same cycle.

module minifloat_add_mul_convert_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    mfac_stream_if.sink         req,
    mfac_stream_if.source       rsp
);

    // ------------------------------------------------------------------
    // Operand register
    // ------------------------------------------------------------------
    logic                  opnd_valid_reg;
    mfac_pkg::req_item_t   opnd_reg;
    logic                  rslt_valid_reg;
    mfac_pkg::rsp_item_t   rslt_reg;
    mfac_pkg::rsp_item_t   rslt_next;
    logic                  rslt_ready;
    logic                  req_fire;

    // The result register frees when empty or taken this cycle; the operand
    // register frees when its item moves on to the result register.
    assign rslt_ready = !rslt_valid_reg || rsp.ready;
    assign req.ready  = !opnd_valid_reg || rslt_ready;
    assign req_fire   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opnd_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            opnd_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            opnd_reg <= req.data;
        end
    end

    // ------------------------------------------------------------------
    // Operand fields
    // ------------------------------------------------------------------
    logic [mfac_pkg::EXP_BITS-1:0]  exp_a;
    logic [mfac_pkg::EXP_BITS-1:0]  exp_b;
    logic [mfac_pkg::FRAC_BITS-1:0] frac_a;
    logic [mfac_pkg::FRAC_BITS:0]   mant_a;
    logic [mfac_pkg::FRAC_BITS:0]   mant_b;

    assign exp_a  = opnd_reg.operand_a[mfac_pkg::MINI_BITS-1:mfac_pkg::FRAC_BITS];
    assign exp_b  = opnd_reg.operand_b[mfac_pkg::MINI_BITS-1:mfac_pkg::FRAC_BITS];
    assign frac_a = opnd_reg.operand_a[mfac_pkg::FRAC_BITS-1:0];
    assign mant_a = {1'b1, frac_a};
    assign mant_b = {1'b1, opnd_reg.operand_b[mfac_pkg::FRAC_BITS-1:0]};

    // ------------------------------------------------------------------
    // Add: align the smaller operand to the larger exponent, add, renormalize
    // ------------------------------------------------------------------
    logic [mfac_pkg::EXP_BITS-1:0]  add_exp_big;
    logic [mfac_pkg::EXP_BITS-1:0]  add_shift;
    logic [mfac_pkg::FRAC_BITS:0]   add_mant_big;
    logic [mfac_pkg::FRAC_BITS:0]   add_mant_small;
    logic [mfac_pkg::FRAC_BITS:0]   add_mant_aligned;
    logic [mfac_pkg::FRAC_BITS+1:0] add_sum;
    logic [mfac_pkg::EXP_BITS:0]    add_exp;
    logic [mfac_pkg::FRAC_BITS-1:0] add_frac;

    always_comb
    begin
        if (exp_a >= exp_b)
        begin
            add_exp_big    = exp_a;
            add_shift      = exp_a - exp_b;
            add_mant_big   = mant_a;
            add_mant_small = mant_b;
        end
        else
        begin
            add_exp_big    = exp_b;
            add_shift      = exp_b - exp_a;
            add_mant_big   = mant_b;
            add_mant_small = mant_a;
        end
        // A shift of nine or more places leaves nothing of the smaller mantissa.
        add_mant_aligned = add_mant_small >> add_shift;
        add_sum          = {1'b0, add_mant_big} + {1'b0, add_mant_aligned};
        if (add_sum[mfac_pkg::FRAC_BITS+1])
        begin
            add_exp  = {1'b0, add_exp_big} + 7'd1;
            add_frac = add_sum[mfac_pkg::FRAC_BITS:1];
        end
        else
        begin
            add_exp  = {1'b0, add_exp_big};
            add_frac = add_sum[mfac_pkg::FRAC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Multiply: 9x9 mantissa product, exponents summed less the bias
    // ------------------------------------------------------------------
    logic [2*mfac_pkg::FRAC_BITS+1:0] mul_prod;
    logic signed [8:0]                mul_exp;
    logic [mfac_pkg::FRAC_BITS-1:0]   mul_frac;

    always_comb
    begin
        mul_prod = {9'd0, mant_a} * {9'd0, mant_b};
        mul_exp  = $signed({3'b000, exp_a}) + $signed({3'b000, exp_b})
                 - $signed({3'b000, mfac_pkg::BIAS})
                 + $signed({8'd0, mul_prod[2*mfac_pkg::FRAC_BITS+1]});
        if (mul_prod[2*mfac_pkg::FRAC_BITS+1])
        begin
            mul_frac = mul_prod[2*mfac_pkg::FRAC_BITS:mfac_pkg::FRAC_BITS+1];
        end
        else
        begin
            mul_frac = mul_prod[2*mfac_pkg::FRAC_BITS-1:mfac_pkg::FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // IEEE single to minifloat: rebias the exponent, truncate the fraction
    // ------------------------------------------------------------------
    logic [7:0]                     sgl_exp;
    logic signed [9:0]              cvt_exp;
    logic [mfac_pkg::FRAC_BITS-1:0] cvt_frac;
    logic                           sgl_negative;

    assign sgl_exp  = opnd_reg.operand_a[30:mfac_pkg::SGL_FRAC_BITS];
    assign cvt_exp  = $signed({2'b00, sgl_exp}) - $signed({2'b00, mfac_pkg::SGL_BIAS})
                    + $signed({4'd0, mfac_pkg::BIAS});
    assign cvt_frac = opnd_reg.operand_a[mfac_pkg::SGL_FRAC_BITS-1:
                                         mfac_pkg::SGL_FRAC_BITS-mfac_pkg::FRAC_BITS];
    // Negative zero converts as zero; any other negative input is flagged.
    assign sgl_negative = opnd_reg.operand_a[31] && (opnd_reg.operand_a[30:0] != 31'd0);

    // ------------------------------------------------------------------
    // Minifloat to IEEE single
    // ------------------------------------------------------------------
    logic [7:0] out_sgl_exp;

    assign out_sgl_exp = {2'b00, exp_a} - {2'b00, mfac_pkg::BIAS} + mfac_pkg::SGL_BIAS;

    // ------------------------------------------------------------------
    // Result select and packing
    // ------------------------------------------------------------------
    always_comb
    begin
        rslt_next.result = 32'd0;
        rslt_next.status = mfac_pkg::STAT_NORMAL;
        case (opnd_reg.func)
            mfac_pkg::FUNC_ADD:
            begin
                if (add_exp > {1'b0, mfac_pkg::EXP_TOP})
                begin
                    rslt_next.result = {18'd0, mfac_pkg::OVF_CODE};
                    rslt_next.status = mfac_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    rslt_next.result = {18'd0, add_exp[mfac_pkg::EXP_BITS-1:0], add_frac};
                    if (add_exp == 7'd0)
                    begin
                        rslt_next.status = mfac_pkg::STAT_UNDERFLOW;
                    end
                end
            end
            mfac_pkg::FUNC_MUL:
            begin
                if (mul_exp < 9'sd1)
                begin
                    rslt_next.status = mfac_pkg::STAT_UNDERFLOW;
                end
                else if (mul_exp > $signed({3'b000, mfac_pkg::EXP_TOP}))
                begin
                    rslt_next.result = {18'd0, mfac_pkg::OVF_CODE};
                    rslt_next.status = mfac_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    rslt_next.result = {18'd0, mul_exp[mfac_pkg::EXP_BITS-1:0], mul_frac};
                end
            end
            mfac_pkg::FUNC_FROM_SGL:
            begin
                // Zero and denormal inputs fall below the range along with small exponents.
                if ((sgl_exp == 8'd0) || (cvt_exp < 10'sd1))
                begin
                    rslt_next.status = mfac_pkg::STAT_UNDERFLOW;
                end
                else if (cvt_exp > $signed({4'd0, mfac_pkg::EXP_TOP}))
                begin
                    rslt_next.result = {18'd0, mfac_pkg::OVF_CODE};
                    rslt_next.status = mfac_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    rslt_next.result = {18'd0, cvt_exp[mfac_pkg::EXP_BITS-1:0], cvt_frac};
                end
                if (sgl_negative)
                begin
                    rslt_next.status = mfac_pkg::STAT_OVERFLOW;
                end
            end
            default:
            begin
                if (exp_a == mfac_pkg::EXP_ALL)
                begin
                    rslt_next.result = mfac_pkg::SGL_MINUS_ONE;
                    rslt_next.status = mfac_pkg::STAT_OVERFLOW;
                end
                else if (exp_a == '0)
                begin
                    rslt_next.status = mfac_pkg::STAT_UNDERFLOW;
                end
                else
                begin
                    rslt_next.result = {1'b0, out_sgl_exp, frac_a, 15'd0};
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register: hold while rsp stalls, advance when free
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rslt_valid_reg <= 1'b0;
        end
        else if (rslt_ready)
        begin
            rslt_valid_reg <= opnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rslt_ready && opnd_valid_reg)
        begin
            rslt_reg <= rslt_next;
        end
    end

    assign rsp.valid = rslt_valid_reg;
    assign rsp.data  = rslt_reg;

`ifndef ASSERT_OFF
    // An accepted item always lands in the operand register.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> opnd_valid_reg)
        else $error("accepted item not held in operand register");

    // A full operand register that cannot advance keeps its item.
    a_operand_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (opnd_valid_reg && !rslt_ready) |=> (opnd_valid_reg && $stable(opnd_reg)))
        else $error("operand register lost its item during a stall");

    // An empty result register never backpressures the input.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rslt_valid_reg |-> req.ready)
        else $error("input stalled with an empty pipeline");

    // Underflow and zero results carry a zero exponent field and no upper bits.
    a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rslt_valid_reg && (rslt_reg.status == mfac_pkg::STAT_UNDERFLOW))
        |-> (rslt_reg.result[31:mfac_pkg::FRAC_BITS] == 24'd0))
        else $error("underflow status with nonzero exponent");
`endif

endmodule

`default_nettype wire
